@@ hw/rtl/adcdc_pkg.sv @@
// ----------------------------------------------------------------------------
// adcdc_pkg
// Shared constants and word types of the ADC DC removal and block statistics
// block.
// ----------------------------------------------------------------------------
package adcdc_pkg;

  localparam int CodeW = 12;
  localparam logic [CodeW-1:0] CodeMax = 12'd4095;
  localparam logic [CodeW-1:0] DcReset = 12'd2048;

  localparam int VrefW = 13;
  localparam logic [VrefW-1:0] VrefReset = 13'd3070;

  localparam int BlockLog = 8;
  localparam int BlockLen = 1 << BlockLog;
  localparam logic [BlockLog-1:0] LastIdx = BlockLog'(BlockLen - 1);
  localparam int SumW = CodeW + BlockLog;

  localparam int CentW = CodeW + 1;
  localparam int CenteredW = 25;
  localparam int ProdW = CodeW + VrefW;
  localparam int BiasDiv = 4095;

  localparam int CmdDepth = 4;
  localparam int CmdPtrW = 2;
  localparam int ResDepth = 8;
  localparam int ResPtrW = 3;

  typedef struct packed {
    logic [CodeW-1:0] raw;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic signed [CenteredW-1:0] centered_sample;
    logic                        block_last;
    logic [CodeW-1:0]            block_average;
    logic [CodeW-1:0]            block_minimum;
    logic [CodeW-1:0]            block_maximum;
    logic [CodeW-1:0]            block_peak;
    logic [CodeW-1:0]            block_abs_average;
    logic [CodeW-1:0]            smoothed_level;
    logic [VrefW-1:0]            bias_millivolts;
  } res_t;

endpackage

@@ hw/rtl/adcdc_front.sv @@
// ----------------------------------------------------------------------------
// adcdc_front
// Accepts raw samples, clamps them to the 12-bit code range and tags the last
// sample of each block.
// ----------------------------------------------------------------------------
module adcdc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 full_i,
  input  logic [15:0]          raw_sample_i,
  output logic                 cmd_we_o,
  output adcdc_pkg::cmd_t      cmd_o
);

  logic [adcdc_pkg::BlockLog-1:0] idx_q, idx_d;
  logic                           accept;
  logic                           last;

  assign accept = push_i & ~full_i;
  assign last   = (idx_q == adcdc_pkg::LastIdx);

  always_comb begin
    idx_d = idx_q;
    if (accept) begin
      idx_d = last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  assign cmd_we_o   = accept;
  assign cmd_o.raw  = (|raw_sample_i[15:adcdc_pkg::CodeW]) ? adcdc_pkg::CodeMax
                                                           : raw_sample_i[adcdc_pkg::CodeW-1:0];
  assign cmd_o.last = last;

endmodule

@@ hw/rtl/adcdc_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// adcdc_cmd_fifo
// Short queue of classified samples between the front and the back.
// ----------------------------------------------------------------------------
module adcdc_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  adcdc_pkg::cmd_t wdata_i,
  output logic            full_o,
  input  logic            re_i,
  output adcdc_pkg::cmd_t rdata_o,
  output logic            empty_o
);

  adcdc_pkg::cmd_t                mem_q [adcdc_pkg::CmdDepth];
  logic [adcdc_pkg::CmdPtrW:0]    wr_q, rd_q;

  assign empty_o = (wr_q == rd_q);
  assign full_o  = (wr_q[adcdc_pkg::CmdPtrW] != rd_q[adcdc_pkg::CmdPtrW]) &&
                   (wr_q[adcdc_pkg::CmdPtrW-1:0] == rd_q[adcdc_pkg::CmdPtrW-1:0]);
  assign rdata_o = mem_q[rd_q[adcdc_pkg::CmdPtrW-1:0]];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_q[adcdc_pkg::CmdPtrW-1:0]] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (we_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (re_i) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/adcdc_res_fifo.sv @@
// ----------------------------------------------------------------------------
// adcdc_res_fifo
// Result queue; the back reserves an entry before it issues a sample.
// ----------------------------------------------------------------------------
module adcdc_res_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  adcdc_pkg::res_t wdata_i,
  input  logic            re_i,
  output adcdc_pkg::res_t rdata_o,
  output logic            empty_o
);

  adcdc_pkg::res_t                mem_q [adcdc_pkg::ResDepth];
  logic [adcdc_pkg::ResPtrW:0]    wr_q, rd_q;

  assign empty_o = (wr_q == rd_q);
  assign rdata_o = mem_q[rd_q[adcdc_pkg::ResPtrW-1:0]];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_q[adcdc_pkg::ResPtrW-1:0]] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (we_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (re_i) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/adcdc_back.sv @@
// ----------------------------------------------------------------------------
// adcdc_back
// DC tracker, block statistics pipeline and bias conversion.
// ----------------------------------------------------------------------------
module adcdc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [adcdc_pkg::VrefW-1:0]   cfg_wdata_i,
  input  logic                          cmd_empty_i,
  input  adcdc_pkg::cmd_t               cmd_i,
  output logic                          cmd_re_o,
  input  logic                          res_pop_i,
  output logic                          res_we_o,
  output adcdc_pkg::res_t               res_o
);

  localparam int W = adcdc_pkg::CodeW;
  localparam int CW = adcdc_pkg::CentW;
  localparam int SW = adcdc_pkg::SumW;
  localparam int PW = adcdc_pkg::ProdW;
  localparam int VW = adcdc_pkg::VrefW;
  localparam int RW = adcdc_pkg::ResPtrW + 1;

  logic [VW-1:0] vref_q;
  logic [RW-1:0] res_q, res_d;
  logic          issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vref_q <= adcdc_pkg::VrefReset;
    end else if (cfg_we_i) begin
      vref_q <= cfg_wdata_i;
    end
  end

  assign issue    = ~cmd_empty_i & (res_q != RW'(adcdc_pkg::ResDepth));
  assign cmd_re_o = issue;
  assign res_d    = res_q + RW'(issue) - RW'(res_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  // Stage 1: DC tracker.
  logic [W-1:0]         dc_q, dc_d;
  logic signed [CW-1:0] diff, diff_adj, step, cent;
  logic                 v1_q;
  logic [W-1:0]         s1_raw_q;
  logic signed [CW-1:0] s1_cent_q;
  logic                 s1_last_q;

  always_comb begin
    diff     = signed'({1'b0, cmd_i.raw}) - signed'({1'b0, dc_q});
    diff_adj = diff + (diff[CW-1] ? CW'(127) : CW'(0));
    step     = diff_adj >>> 7;
    dc_d     = dc_q + step[W-1:0];
    cent     = signed'({1'b0, cmd_i.raw}) - signed'({1'b0, dc_d});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q <= adcdc_pkg::DcReset;
      v1_q <= 1'b0;
    end else begin
      v1_q <= issue;
      if (issue) begin
        dc_q <= dc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_raw_q  <= cmd_i.raw;
      s1_cent_q <= cent;
      s1_last_q <= cmd_i.last;
    end
  end

  // Stage 2: block accumulators.
  logic [CW-1:0]        neg_cent;
  logic [W-1:0]         mag;
  logic [SW-1:0]        rsum_q, msum_q, rsum_n, msum_n;
  logic [W-1:0]         min_q, max_q, peak_q, min_n, max_n, peak_n;
  logic                 v2_q;
  logic signed [CW-1:0] s2_cent_q;
  logic                 s2_last_q;
  logic [SW-1:0]        s2_rsum_q, s2_msum_q;
  logic [W-1:0]         s2_min_q, s2_max_q, s2_peak_q;

  always_comb begin
    neg_cent = -s1_cent_q;
    mag      = s1_cent_q[CW-1] ? neg_cent[W-1:0] : s1_cent_q[W-1:0];
    rsum_n   = rsum_q + SW'(s1_raw_q);
    msum_n   = msum_q + SW'(mag);
    min_n    = (s1_raw_q < min_q) ? s1_raw_q : min_q;
    max_n    = (s1_raw_q > max_q) ? s1_raw_q : max_q;
    peak_n   = (mag > peak_q) ? mag : peak_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q   <= 1'b0;
      rsum_q <= '0;
      msum_q <= '0;
      min_q  <= adcdc_pkg::CodeMax;
      max_q  <= '0;
      peak_q <= '0;
    end else begin
      v2_q <= v1_q;
      if (v1_q) begin
        if (s1_last_q) begin
          rsum_q <= '0;
          msum_q <= '0;
          min_q  <= adcdc_pkg::CodeMax;
          max_q  <= '0;
          peak_q <= '0;
        end else begin
          rsum_q <= rsum_n;
          msum_q <= msum_n;
          min_q  <= min_n;
          max_q  <= max_n;
          peak_q <= peak_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      s2_cent_q <= s1_cent_q;
      s2_last_q <= s1_last_q;
      s2_rsum_q <= rsum_n;
      s2_msum_q <= msum_n;
      s2_min_q  <= min_n;
      s2_max_q  <= max_n;
      s2_peak_q <= peak_n;
    end
  end

  // Stage 3: averages, smoothing and the bias product.
  logic [W-1:0]         avg, absavg, ls_q, ls_d;
  logic [W+3:0]         sm_sum;
  logic                 v3_q;
  logic signed [CW-1:0] s3_cent_q;
  logic                 s3_last_q;
  logic [W-1:0]         s3_avg_q, s3_absavg_q, s3_min_q, s3_max_q, s3_peak_q, s3_ls_q;
  logic [PW-1:0]        s3_prod_q;

  always_comb begin
    avg    = s2_rsum_q[SW-1:adcdc_pkg::BlockLog];
    absavg = s2_msum_q[SW-1:adcdc_pkg::BlockLog];
    sm_sum = {1'b0, ls_q, 3'b000} - {4'b0000, ls_q} + {4'b0000, absavg};
    ls_d   = ls_q;
    if (v2_q && s2_last_q) begin
      ls_d = sm_sum[W+2:3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      ls_q <= '0;
    end else begin
      v3_q <= v2_q;
      ls_q <= ls_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      s3_cent_q   <= s2_cent_q;
      s3_last_q   <= s2_last_q;
      s3_avg_q    <= avg;
      s3_absavg_q <= absavg;
      s3_min_q    <= s2_min_q;
      s3_max_q    <= s2_max_q;
      s3_peak_q   <= s2_peak_q;
      s3_ls_q     <= ls_d;
      s3_prod_q   <= PW'(avg) * PW'(vref_q);
    end
  end

  // Division of the product by 4095: quotient estimate from the upper bits,
  // then at most three corrections.
  logic [VW-1:0] q0, bias;
  logic [VW:0]   rem;
  logic [1:0]    corr;

  always_comb begin
    q0  = s3_prod_q[PW-1:W];
    rem = {2'b00, s3_prod_q[W-1:0]} + {1'b0, q0};
    priority if (rem >= (VW+1)'(3 * adcdc_pkg::BiasDiv)) begin
      corr = 2'd3;
    end else if (rem >= (VW+1)'(2 * adcdc_pkg::BiasDiv)) begin
      corr = 2'd2;
    end else if (rem >= (VW+1)'(adcdc_pkg::BiasDiv)) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
    bias = q0 + VW'(corr);
  end

  always_comb begin
    res_o                 = '0;
    res_o.centered_sample = {s3_cent_q, {W{1'b0}}};
    res_o.block_last      = s3_last_q;
    if (s3_last_q) begin
      res_o.block_average     = s3_avg_q;
      res_o.block_minimum     = s3_min_q;
      res_o.block_maximum     = s3_max_q;
      res_o.block_peak        = s3_peak_q;
      res_o.block_abs_average = s3_absavg_q;
      res_o.smoothed_level    = s3_ls_q;
      res_o.bias_millivolts   = bias;
    end
  end

  assign res_we_o = v3_q;

endmodule

@@ hw/rtl/adc_dc_removal_block_statistics_top.sv @@
// ----------------------------------------------------------------------------
// adc_dc_removal_block_statistics_top
// ADC front end that removes DC and reports statistics over blocks of samples.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle on the input queue while it is not
// full and returns one word per accepted sample on the result queue, in order.
// The sustained rate is one word per cycle while the result queue has room,
// set by the DC tracker loop. Blocks are 256 samples long; the statistics fields
// are nonzero only on the word that carries block_last. A four-entry input queue
// and an eight-entry result queue let either side stall without stopping the
// other until a queue fills. The user must write the reference voltage only
// while no samples are in flight; the block itself does not enforce this.
module adc_dc_removal_block_statistics_top (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic [adcdc_pkg::VrefW-1:0]                cfg_wdata_i,
  input  logic                                       push,
  output logic                                       full,
  input  logic [15:0]                                raw_sample_i,
  output logic                                       empty,
  input  logic                                       pop,
  output logic signed [adcdc_pkg::CenteredW-1:0]     centered_sample_o,
  output logic                                       block_last_o,
  output logic [adcdc_pkg::CodeW-1:0]                block_average_o,
  output logic [adcdc_pkg::CodeW-1:0]                block_minimum_o,
  output logic [adcdc_pkg::CodeW-1:0]                block_maximum_o,
  output logic [adcdc_pkg::CodeW-1:0]                block_peak_o,
  output logic [adcdc_pkg::CodeW-1:0]                block_abs_average_o,
  output logic [adcdc_pkg::CodeW-1:0]                smoothed_level_o,
  output logic [adcdc_pkg::VrefW-1:0]                bias_millivolts_o
);

  logic            cmd_we, cmd_re, cmd_full, cmd_empty;
  adcdc_pkg::cmd_t cmd_wdata, cmd_rdata;
  logic            res_we, res_empty, res_pop;
  adcdc_pkg::res_t res_wdata, res_rdata;

  assign full    = cmd_full;
  assign empty   = res_empty;
  assign res_pop = pop & ~res_empty;

  adcdc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (cmd_full),
    .raw_sample_i (raw_sample_i),
    .cmd_we_o     (cmd_we),
    .cmd_o        (cmd_wdata)
  );

  adcdc_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cmd_we),
    .wdata_i (cmd_wdata),
    .full_o  (cmd_full),
    .re_i    (cmd_re),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  adcdc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_rdata),
    .cmd_re_o    (cmd_re),
    .res_pop_i   (res_pop),
    .res_we_o    (res_we),
    .res_o       (res_wdata)
  );

  adcdc_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (res_we),
    .wdata_i (res_wdata),
    .re_i    (res_pop),
    .rdata_o (res_rdata),
    .empty_o (res_empty)
  );

  assign centered_sample_o   = res_rdata.centered_sample;
  assign block_last_o        = res_rdata.block_last;
  assign block_average_o     = res_rdata.block_average;
  assign block_minimum_o     = res_rdata.block_minimum;
  assign block_maximum_o     = res_rdata.block_maximum;
  assign block_peak_o        = res_rdata.block_peak;
  assign block_abs_average_o = res_rdata.block_abs_average;
  assign smoothed_level_o    = res_rdata.smoothed_level;
  assign bias_millivolts_o   = res_rdata.bias_millivolts;

endmodule

@@ hw/rtl/adcdc_checker.sv @@
// ----------------------------------------------------------------------------
// adcdc_checker
// Port-level checks of the DC removal and block statistics top level.
// ----------------------------------------------------------------------------
module adcdc_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   pop,
  input logic                                   empty,
  input logic signed [adcdc_pkg::CenteredW-1:0] centered_sample_o,
  input logic                                   block_last_o,
  input logic [adcdc_pkg::CodeW-1:0]            block_average_o,
  input logic [adcdc_pkg::CodeW-1:0]            block_minimum_o,
  input logic [adcdc_pkg::CodeW-1:0]            block_maximum_o,
  input logic [adcdc_pkg::CodeW-1:0]            block_peak_o,
  input logic [adcdc_pkg::CodeW-1:0]            block_abs_average_o,
  input logic [adcdc_pkg::CodeW-1:0]            smoothed_level_o,
  input logic [adcdc_pkg::VrefW-1:0]            bias_millivolts_o
);

  a_empty_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> empty)
    else $error("Result queue not empty after reset.");

  a_held_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(centered_sample_o) &&
                          $stable(block_last_o)))
    else $error("Waiting result word changed before it was taken.");

  a_stats_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !block_last_o) |-> (block_average_o == '0 && block_minimum_o == '0 &&
                                   block_maximum_o == '0 && block_peak_o == '0 &&
                                   block_abs_average_o == '0 && smoothed_level_o == '0 &&
                                   bias_millivolts_o == '0))
    else $error("Statistics present on a word that does not end a block.");

  a_stats_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && block_last_o) |-> (block_minimum_o <= block_average_o &&
                                  block_average_o <= block_maximum_o &&
                                  block_abs_average_o <= block_peak_o))
    else $error("Block statistics out of order.");

endmodule

bind adc_dc_removal_block_statistics_top adcdc_checker u_adcdc_checker (.*);

@@ bench/adc_dc_removal_block_statistics_top_tb.sv @@
// ----------------------------------------------------------------------------
// adc_dc_removal_block_statistics_top_tb
// Self-checking bench for the DC removal and block statistics front end. A
// scoreboard class tracks the DC estimate and the block statistics of every
// accepted sample and checks each result word, field by field, in order. The
// run steps through several reference voltages and handshake idle profiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adc_dc_removal_block_statistics_top_tb;

  localparam int TrackDiv = 128;
  localparam int SmoothKeep = 7;
  localparam int SmoothDiv = 8;
  localparam int OutScale = 4096;
  localparam int HoldCycles = 60;
  localparam int SettleCycles = 8;
  localparam int StallLimit = 2000;
  localparam int TailLen = 130;

  class dc_stats_tracker_t;
    adcdc_pkg::res_t pending_words[$];
    int unsigned vref;
    int dc_est;
    int level_est;
    int fill;
    int raw_total;
    int mag_total;
    int low_code;
    int high_code;
    int top_mag;
    int unsigned checked;
    int unsigned mismatches;
    int unsigned blocks_seen;

    function new();
      vref = adcdc_pkg::VrefReset;
      dc_est = adcdc_pkg::DcReset;
      level_est = 0;
      checked = 0;
      mismatches = 0;
      blocks_seen = 0;
      restart_block();
    endfunction

    function void restart_block();
      fill = 0;
      raw_total = 0;
      mag_total = 0;
      low_code = adcdc_pkg::CodeMax;
      high_code = 0;
      top_mag = 0;
    endfunction

    function void set_vref(logic [adcdc_pkg::VrefW-1:0] v);
      vref = v;
    endfunction

    function void take_sample(logic [15:0] raw);
      int code;
      int cent;
      int mag;
      int avg;
      int abs_avg;
      int unsigned bias;
      adcdc_pkg::res_t w;
      code = (raw > 16'(adcdc_pkg::CodeMax)) ? int'(adcdc_pkg::CodeMax) : int'(raw);
      dc_est += (code - dc_est) / TrackDiv;
      cent = code - dc_est;
      mag = (cent < 0) ? -cent : cent;
      w = '0;
      w.centered_sample = adcdc_pkg::CenteredW'(cent * OutScale);
      if (code < low_code) low_code = code;
      if (code > high_code) high_code = code;
      if (mag > top_mag) top_mag = mag;
      raw_total += code;
      mag_total += mag;
      fill++;
      if (fill >= adcdc_pkg::BlockLen) begin
        avg = raw_total / adcdc_pkg::BlockLen;
        abs_avg = mag_total / adcdc_pkg::BlockLen;
        if (avg > int'(adcdc_pkg::CodeMax)) avg = adcdc_pkg::CodeMax;
        if (abs_avg > int'(adcdc_pkg::CodeMax)) abs_avg = adcdc_pkg::CodeMax;
        level_est = ((level_est * SmoothKeep + abs_avg) / SmoothDiv) &
                    int'(adcdc_pkg::CodeMax);
        bias = (avg * vref) / adcdc_pkg::BiasDiv;
        w.block_last = 1'b1;
        w.block_average = adcdc_pkg::CodeW'(avg);
        w.block_minimum = adcdc_pkg::CodeW'(low_code);
        w.block_maximum = adcdc_pkg::CodeW'(high_code);
        w.block_peak = adcdc_pkg::CodeW'(top_mag);
        w.block_abs_average = adcdc_pkg::CodeW'(abs_avg);
        w.smoothed_level = adcdc_pkg::CodeW'(level_est);
        w.bias_millivolts = adcdc_pkg::VrefW'(bias);
        blocks_seen++;
        restart_block();
      end
      pending_words.push_back(w);
    endfunction

    function string describe(adcdc_pkg::res_t w);
      return $sformatf({"cent=%0d last=%0b avg=%0d min=%0d max=%0d peak=%0d",
                        " absavg=%0d smooth=%0d mv=%0d"},
                       w.centered_sample, w.block_last, w.block_average, w.block_minimum,
                       w.block_maximum, w.block_peak, w.block_abs_average, w.smoothed_level,
                       w.bias_millivolts);
    endfunction

    function void match_word(adcdc_pkg::res_t got);
      adcdc_pkg::res_t want;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("word with nothing pending: %s", describe(got));
      end else begin
        want = pending_words.pop_front();
        checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("word %0d mismatch", checked);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(got));
          end
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [adcdc_pkg::VrefW-1:0] cfg_wdata_i;
  logic push;
  logic full;
  logic [15:0] raw_sample_i;
  logic empty;
  logic pop;
  logic signed [adcdc_pkg::CenteredW-1:0] centered_sample_o;
  logic block_last_o;
  logic [adcdc_pkg::CodeW-1:0] block_average_o;
  logic [adcdc_pkg::CodeW-1:0] block_minimum_o;
  logic [adcdc_pkg::CodeW-1:0] block_maximum_o;
  logic [adcdc_pkg::CodeW-1:0] block_peak_o;
  logic [adcdc_pkg::CodeW-1:0] block_abs_average_o;
  logic [adcdc_pkg::CodeW-1:0] smoothed_level_o;
  logic [adcdc_pkg::VrefW-1:0] bias_millivolts_o;

  dc_stats_tracker_t tracker = new();
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit hold_req;

  adc_dc_removal_block_statistics_top i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .push                (push),
    .full                (full),
    .raw_sample_i        (raw_sample_i),
    .empty               (empty),
    .pop                 (pop),
    .centered_sample_o   (centered_sample_o),
    .block_last_o        (block_last_o),
    .block_average_o     (block_average_o),
    .block_minimum_o     (block_minimum_o),
    .block_maximum_o     (block_maximum_o),
    .block_peak_o        (block_peak_o),
    .block_abs_average_o (block_abs_average_o),
    .smoothed_level_o    (smoothed_level_o),
    .bias_millivolts_o   (bias_millivolts_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_word(input logic [15:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    raw_sample_i <= raw;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    tracker.take_sample(raw);
  endtask

  task automatic wait_for_drain();
    push <= 1'b0;
    while (tracker.pending_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_vref(input logic [adcdc_pkg::VrefW-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_vref(v);
  endtask

  task automatic stream_samples(input int count, input int pause_at);
    int center;
    int code;
    int unsigned sel;
    logic [15:0] raw;
    center = $urandom_range(4095);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) wait_for_drain();
      sel = $urandom_range(99);
      if (sel < 50) begin
        code = center + int'($urandom_range(400)) - 200;
        if (code < 0) code = 0;
        if (code > int'(adcdc_pkg::CodeMax)) code = adcdc_pkg::CodeMax;
        raw = 16'(code);
      end else if (sel < 75) begin
        raw = 16'($urandom_range(4095));
      end else if (sel < 88) begin
        raw = 16'($urandom_range(65535));
      end else begin
        case ($urandom_range(3))
          0: raw = 16'd0;
          1: raw = 16'(adcdc_pkg::CodeMax);
          2: raw = 16'd4096;
          default: raw = 16'hFFFF;
        endcase
      end
      send_word(raw);
    end
  endtask

  initial begin : result_sink
    int hold_left;
    adcdc_pkg::res_t got;
    hold_left = 0;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got.centered_sample = centered_sample_o;
        got.block_last = block_last_o;
        got.block_average = block_average_o;
        got.block_minimum = block_minimum_o;
        got.block_maximum = block_maximum_o;
        got.block_peak = block_peak_o;
        got.block_abs_average = block_abs_average_o;
        got.smoothed_level = smoothed_level_o;
        got.bias_millivolts = bias_millivolts_o;
        tracker.match_word(got);
      end
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stall_watch
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("adc_dc_removal_block_statistics_top_tb: errors");
    $finish;
  end

  initial begin : main_flow
    logic [15:0] corner_codes [20];
    corner_codes = '{16'd0, 16'hFFFF, 16'd4095, 16'd4096, 16'd1, 16'd4094, 16'd2048,
                     16'd2047, 16'h8000, 16'h5555, 16'hAAAA, 16'h0FFF, 16'h1000, 16'd0,
                     16'd0, 16'd4095, 16'd4095, 16'd3000, 16'd100, 16'hFFFE};
    push <= 1'b0;
    raw_sample_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    hold_req = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 84;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_codes[i]) send_word(corner_codes[i]);
    stream_samples(adcdc_pkg::BlockLen - 20, -1);
    wait_for_drain();

    write_vref('0);
    stream_samples(adcdc_pkg::BlockLen, -1);
    wait_for_drain();

    send_idle_pct = 84;
    recv_idle_pct = 19;
    write_vref('1);
    stream_samples(adcdc_pkg::BlockLen, adcdc_pkg::BlockLen / 2);
    wait_for_drain();

    write_vref(adcdc_pkg::VrefW'(5000));
    stream_samples(adcdc_pkg::BlockLen, -1);
    wait_for_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_vref(adcdc_pkg::VrefW'($urandom_range(5000)));
    hold_req = 1'b1;
    stream_samples(TailLen, -1);
    wait_for_drain();

    $display("Checked %0d samples and %0d full blocks under five reference settings,",
             tracker.checked, tracker.blocks_seen);
    $display("with sender-idle, receiver-idle and back-to-back traffic plus a full stall.");
    if (tracker.mismatches == 0 && tracker.pending_words.size() == 0) begin
      $display("adc_dc_removal_block_statistics_top_tb: clean");
    end else begin
      $display("adc_dc_removal_block_statistics_top_tb: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/adcdc_pkg.sv
hw/rtl/adcdc_front.sv
hw/rtl/adcdc_cmd_fifo.sv
hw/rtl/adcdc_res_fifo.sv
hw/rtl/adcdc_back.sv
hw/rtl/adc_dc_removal_block_statistics_top.sv
hw/rtl/adcdc_checker.sv
bench/adc_dc_removal_block_statistics_top_tb.sv
